// ===== sv/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants for the motor speed ramp
// Command codes, speed code limits, pulse mapping constants and register
// indexes used by the ramp, the pulse mapper and the top level.
// ----------------------------------------------------------------------------
package msr_pkg;

	localparam int CMD_W   = 2;
	localparam int CODE_W  = 8;
	localparam int MAG_W   = 7;
	localparam int PULSE_A_W = 21;
	localparam int PULSE_B_W = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 56;

	localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_KIND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'b1;

	localparam logic KIND_DC = 1'b0;
	localparam logic KIND_RESET = 1'b0;
	localparam logic [CODE_W-1:0] STEP_RESET = 8'd10;

	localparam logic [CODE_W-1:0] SPEED_MID   = 8'd127;
	localparam logic [CODE_W-1:0] TARGET_LOW  = 8'd27;
	localparam logic [CODE_W-1:0] TARGET_HIGH = 8'd227;
	localparam logic [MAG_W-1:0]  SPEED_LIMIT = 7'd100;

	localparam logic [13:0]          DC_PULSE_PER_UNIT = 14'd9999;
	localparam logic [12:0]          BL_PULSE_PER_UNIT = 13'd5000;
	localparam logic [PULSE_A_W-1:0] BL_PULSE_MID      = 21'd1500000;

	typedef struct packed {
		logic              emit;
		logic              idle;
		logic [CODE_W-1:0] code;
	} ramp_res_t;

endpackage

// ===== sv/msr_ramp.sv =====
// ----------------------------------------------------------------------------
// msr_ramp: target and current speed code state
// Clamps set commands into the target, steps the current code toward the
// target on ticks and flags which commands give a result word.
// ----------------------------------------------------------------------------
module msr_ramp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [msr_pkg::CMD_W-1:0]  cmd,
	input  logic [msr_pkg::CODE_W-1:0] req,
	input  logic [msr_pkg::CODE_W-1:0] step_size,
	output msr_pkg::ramp_res_t         res
);
	import msr_pkg::*;

	logic [CODE_W-1:0] target_q;
	logic [CODE_W-1:0] current_q;
	logic [CODE_W-1:0] req_clamped;
	logic [CODE_W-1:0] next_code;
	logic signed [CODE_W:0] diff;
	logic signed [CODE_W:0] lim;
	logic signed [CODE_W:0] step;
	logic is_tick;
	logic moves;

	always_comb begin
		if (req < TARGET_LOW) begin
			req_clamped = TARGET_LOW;
		end else if (req > TARGET_HIGH) begin
			req_clamped = TARGET_HIGH;
		end else begin
			req_clamped = req;
		end
	end

	// signed distance to target, limited to plus or minus step_size
	always_comb begin
		diff = $signed({1'b0, target_q}) - $signed({1'b0, current_q});
		lim  = $signed({1'b0, step_size});
		if (diff > lim) begin
			step = lim;
		end else if (diff < -lim) begin
			step = -lim;
		end else begin
			step = diff;
		end
		next_code = current_q + step[CODE_W-1:0];
	end

	assign is_tick = (cmd == CMD_TICK);
	assign moves   = is_tick && (current_q != target_q);

	always_comb begin
		res.emit = moves || (cmd == CMD_OFF);
		res.idle = (cmd == CMD_OFF);
		res.code = moves ? next_code : current_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= SPEED_MID;
			current_q <= SPEED_MID;
		end else if (adv) begin
			case (cmd)
				CMD_SET: target_q <= req_clamped;
				CMD_OFF: target_q <= SPEED_MID;
				default: ;
			endcase
			if (moves) begin
				current_q <= next_code;
			end
		end
	end

endmodule

// ===== sv/msr_map.sv =====
// ----------------------------------------------------------------------------
// msr_map: speed code to pulse width mapping
// Turns the current speed code into nanosecond pulse widths for the DC
// H-bridge or the brushless servo pulse.
// ----------------------------------------------------------------------------
module msr_map (
	input  logic                          motor_kind,
	input  logic                          idle,
	input  logic [msr_pkg::CODE_W-1:0]    code,
	output logic [msr_pkg::PULSE_A_W-1:0] pulse_a,
	output logic [msr_pkg::PULSE_B_W-1:0] pulse_b
);
	import msr_pkg::*;

	logic signed [CODE_W:0] lvl;
	logic                   neg;
	logic [MAG_W-1:0]       mag;
	logic [PULSE_A_W-1:0]   dc_prod;
	logic [PULSE_A_W-1:0]   bl_prod;

	// level relative to stop, magnitude limited to 100
	always_comb begin
		lvl = $signed({1'b0, code}) - $signed({1'b0, SPEED_MID});
		neg = lvl[CODE_W];
		if (idle) begin
			mag = '0;
		end else if (neg) begin
			mag = (-lvl > $signed({2'b0, SPEED_LIMIT})) ? SPEED_LIMIT : MAG_W'(-lvl);
		end else begin
			mag = (lvl > $signed({2'b0, SPEED_LIMIT})) ? SPEED_LIMIT : lvl[MAG_W-1:0];
		end
	end

	assign dc_prod = PULSE_A_W'(mag) * DC_PULSE_PER_UNIT;
	assign bl_prod = PULSE_A_W'(mag) * BL_PULSE_PER_UNIT;

	always_comb begin
		if (motor_kind != KIND_DC) begin
			pulse_a = neg ? (BL_PULSE_MID - bl_prod) : (BL_PULSE_MID + bl_prod);
			pulse_b = '0;
		end else if (neg) begin
			pulse_a = '0;
			pulse_b = dc_prod[PULSE_B_W-1:0];
		end else begin
			pulse_a = dc_prod;
			pulse_b = '0;
		end
	end

endmodule

// ===== sv/motor_speed_ramp_pwm.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_pwm: slew-rate limited speed ramp with pwm pulse mapping
// Input register, ramp state and pulse mapper, and an output register.
// ----------------------------------------------------------------------------
// Takes one command word per clock unless the output side holds it. A word
// waits in the input register while the ramp state is updated and the pulse
// widths are mapped; any result word is loaded into the output register,
// which drives the master side. Set commands and ticks that find the current
// code already at the target give no result word. The input keeps flowing
// while a result waits; only a result-bearing command meeting a full, stalled
// output register holds the input side.
module motor_speed_ramp_pwm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [msr_pkg::IN_DATA_W-1:0]     s_tdata,   // cmd, target_speed
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [msr_pkg::OUT_DATA_W-1:0]    m_tdata,   // pulse_a, pulse_b, speed_now
	input  logic                              cfg_we,
	input  logic [msr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import msr_pkg::*;

	logic                 kind_q;
	logic [CODE_W-1:0]    step_q;
	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [CODE_W-1:0]    req_s1;
	logic                 adv_s1;
	ramp_res_t            res;
	logic [PULSE_A_W-1:0] pulse_a;
	logic [PULSE_B_W-1:0] pulse_b;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MOTOR_KIND: kind_q <= cfg_data[0];
				CFG_STEP_SIZE:  step_q <= cfg_data;
			endcase
		end
	end

	// a word with no result never waits for the output register
	assign adv_s1   = valid_s1 && (!res.emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[CMD_W-1:0];
			req_s1 <= s_tdata[CMD_W+CODE_W-1:CMD_W];
		end
	end

	msr_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s1),
		.cmd       (cmd_s1),
		.req       (req_s1),
		.step_size (step_q),
		.res       (res)
	);

	msr_map u_map (
		.motor_kind (kind_q),
		.idle       (res.idle),
		.code       (res.code),
		.pulse_a    (pulse_a),
		.pulse_b    (pulse_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			out_data_q <= {7'b0, res.code, pulse_b, pulse_a};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_dc_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PULSE_A_W-1:0] == '0)
			|| (m_tdata[PULSE_A_W+PULSE_B_W-1:PULSE_A_W] == '0))
		else $error("both h-bridge sides driven");

	a_bl_no_b: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_q != KIND_DC) |-> (m_tdata[PULSE_A_W+PULSE_B_W-1:PULSE_A_W] == '0))
		else $error("second channel active in brushless mode");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(cmd_s1) && $stable(req_s1)))
		else $error("input register lost a held word");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for motor_speed_ramp_pwm
// Drives command words on the slave stream and checks every pulse word on the
// master stream against a behavioral ramp and pulse mapper kept in a small
// scoreboard. Covers clamped targets, ramps at several step sizes (zero and
// the extremes among them), off commands, the unused command code, both motor
// kinds, and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import msr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		logic [PULSE_A_W-1:0] pulse_a;
		logic [PULSE_B_W-1:0] pulse_b;
		logic [CODE_W-1:0]    speed_now;
	} pulse_word_t;

	class ramp_scoreboard;
		logic              kind;
		logic [CODE_W-1:0] step;
		logic [CODE_W-1:0] target_code;
		logic [CODE_W-1:0] current_code;
		pulse_word_t       pulse_q[$];
		int                fail_count;

		function new();
			kind = KIND_RESET;
			step = STEP_RESET;
			target_code = SPEED_MID;
			current_code = SPEED_MID;
			fail_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			if (index == CFG_MOTOR_KIND) begin
				kind = value[0];
			end else begin
				step = value;
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] speed_req);
			int diff;
			int level;
			pulse_word_t w;
			w.pulse_a = '0;
			w.pulse_b = '0;
			case (cmd)
				CMD_SET: begin
					if (speed_req < TARGET_LOW) begin
						target_code = TARGET_LOW;
					end else if (speed_req > TARGET_HIGH) begin
						target_code = TARGET_HIGH;
					end else begin
						target_code = speed_req;
					end
				end
				CMD_TICK: begin
					if (current_code != target_code) begin
						diff = int'(target_code) - int'(current_code);
						if (diff > int'(step)) begin
							diff = int'(step);
						end else if (diff < -int'(step)) begin
							diff = -int'(step);
						end
						current_code = CODE_W'(int'(current_code) + diff);
						level = int'(current_code) - int'(SPEED_MID);
						if (level > int'(SPEED_LIMIT)) begin
							level = int'(SPEED_LIMIT);
						end else if (level < -int'(SPEED_LIMIT)) begin
							level = -int'(SPEED_LIMIT);
						end
						if (kind != KIND_DC) begin
							w.pulse_a = PULSE_A_W'(int'(BL_PULSE_MID) + level * int'(BL_PULSE_PER_UNIT));
						end else if (level > 0) begin
							w.pulse_a = PULSE_A_W'(level * int'(DC_PULSE_PER_UNIT));
						end else if (level < 0) begin
							w.pulse_b = PULSE_B_W'(-level * int'(DC_PULSE_PER_UNIT));
						end
						w.speed_now = current_code;
						pulse_q.push_back(w);
					end
				end
				CMD_OFF: begin
					// target returns to stop, the current code is kept
					target_code = SPEED_MID;
					if (kind != KIND_DC) begin
						w.pulse_a = BL_PULSE_MID;
					end
					w.speed_now = current_code;
					pulse_q.push_back(w);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_pulse(logic [OUT_DATA_W-1:0] data);
			pulse_word_t got;
			pulse_word_t want;
			got.pulse_a = data[PULSE_A_W-1:0];
			got.pulse_b = data[PULSE_A_W +: PULSE_B_W];
			got.speed_now = data[PULSE_A_W+PULSE_B_W +: CODE_W];
			if (pulse_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected word: a=%0d b=%0d speed=%0d",
						got.pulse_a, got.pulse_b, got.speed_now);
				end
			end else begin
				want = pulse_q.pop_front();
				if (got.pulse_a !== want.pulse_a || got.pulse_b !== want.pulse_b ||
						got.speed_now !== want.speed_now) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("pulse mismatch: expected a=%0d b=%0d speed=%0d, got a=%0d b=%0d speed=%0d",
							want.pulse_a, want.pulse_b, want.speed_now,
							got.pulse_a, got.pulse_b, got.speed_now);
					end
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;     // cmd, target_speed
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // pulse_a, pulse_b, speed_now
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ramp_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;

	int phase_kind[NUM_PHASES]  = '{0, 1, 0, 1, 0, 1, 0, 1};
	int phase_step[NUM_PHASES]  = '{1, 255, 10, 3, 255, 1, 37, 10};
	int phase_idle[NUM_PHASES]  = '{0, 73, 0, 28, 28, 73, 0, 0};
	int phase_stall[NUM_PHASES] = '{0, 0, 73, 28, 28, 0, 73, 0};

	motor_speed_ramp_pwm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_pulse(m_tdata);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] speed_req);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W-CMD_W-CODE_W){1'b0}}, speed_req, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, speed_req);
		// each following cycle is idle with the phase probability
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// wait for every pulse word, then let words that give none drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pulse_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(index, value);
	endtask

	function automatic logic [CODE_W-1:0] pick_speed();
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(6))
				0: return 8'd0;
				1: return TARGET_LOW - 8'd1;
				2: return TARGET_LOW;
				3: return SPEED_MID;
				4: return TARGET_HIGH;
				5: return TARGET_HIGH + 8'd1;
				default: return 8'd255;
			endcase
		end
		return CODE_W'($urandom_range(255));
	endfunction

	initial begin
		int sent;
		int n;
		int r;
		logic [CMD_W-1:0] c;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: dc mapping, step 10
		send_word(CMD_TICK, 8'd0);          // already at target, no word
		send_word(CMD_SET, 8'd255);         // clamps high
		repeat (3) send_word(CMD_TICK, 8'd0);
		send_word(CMD_OFF, 8'd0);
		send_word(CMD_TICK, 8'hff);
		send_word(CMD_SET, 8'd0);           // clamps low
		repeat (2) send_word(CMD_TICK, 8'd0);
		send_word(CMD_UNUSED, 8'haa);
		send_word(CMD_SET, TARGET_LOW - 8'd1);
		send_word(CMD_SET, TARGET_HIGH + 8'd1);
		send_word(CMD_SET, SPEED_MID);
		send_word(CMD_TICK, 8'h55);
		settle();

		// brushless at full slew: both ends of the pulse range
		write_reg(CFG_MOTOR_KIND, 8'd1);
		write_reg(CFG_STEP_SIZE, 8'd255);
		send_word(CMD_SET, TARGET_HIGH);
		send_word(CMD_TICK, 8'd0);
		send_word(CMD_SET, TARGET_LOW);
		send_word(CMD_TICK, 8'd0);
		send_word(CMD_OFF, 8'd0);
		send_word(CMD_SET, 8'd200);
		settle();

		// zero step still gives a word per tick with the code held
		write_reg(CFG_STEP_SIZE, 8'd0);
		repeat (2) send_word(CMD_TICK, 8'd0);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_reg(CFG_MOTOR_KIND, CFG_DATA_W'(phase_kind[p]));
			write_reg(CFG_STEP_SIZE, CFG_DATA_W'(phase_step[p]));
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 65) begin
					send_word(CMD_SET, pick_speed());
					n = $urandom_range(1, 12);
					repeat (n) send_word(CMD_TICK, CODE_W'($urandom_range(255)));
					sent += n + 1;
				end else if (r < 80) begin
					send_word(CMD_OFF, CODE_W'($urandom_range(255)));
					n = $urandom_range(1, 6);
					repeat (n) send_word(CMD_TICK, CODE_W'($urandom_range(255)));
					sent += n + 1;
				end else if (r < 95) begin
					case ($urandom_range(2))
						0: c = CMD_SET;
						1: c = CMD_TICK;
						default: c = CMD_OFF;
					endcase
					send_word(c, pick_speed());
					sent++;
				end else begin
					send_word(CMD_UNUSED, CODE_W'($urandom_range(255)));
				end
			end
		end

		idle_pct = 0;
		stall_pct = 0;
		settle();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0 && sb.pulse_q.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
